// ===== rtl/core/lbb_pkg.sv =====
`default_nettype none
package lbb_pkg;

  localparam int unsigned CoordBitsDef      = 16;
  localparam int unsigned WeightFracBitsDef = 16;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned GridW    = 16;
  localparam int unsigned BandW    = 15;
  localparam int unsigned DistW    = 15;
  localparam int unsigned D2W      = 31;
  localparam int unsigned T2W      = 30;
  localparam int unsigned ValW     = 32;
  localparam int unsigned DiffW    = 33;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_BORDER      = 2'd2,
    REG_RAMP        = 2'd3
  } cfg_reg_e;

  // what the back end has to do with a point
  typedef enum logic [1:0] {
    KIND_OUTER = 2'd0,
    KIND_INNER = 2'd1,
    KIND_RAMP  = 2'd2
  } kind_e;

  typedef struct packed {
    logic  vld;
    kind_e kind;
  } tag_t;

endpackage
`default_nettype wire

// ===== rtl/core/lbb_front.sv =====
`default_nettype none
module lbb_front #(
  parameter int unsigned COORD_BITS = lbb_pkg::CoordBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           take_i,
  input  wire logic [COORD_BITS-1:0]          col_i,
  input  wire logic [COORD_BITS-1:0]          row_i,
  input  wire logic signed [lbb_pkg::ValW-1:0] inner_i,
  input  wire logic signed [lbb_pkg::ValW-1:0] outer_i,
  input  wire logic [lbb_pkg::GridW-1:0]      grid_w_i,
  input  wire logic [lbb_pkg::GridW-1:0]      grid_h_i,
  input  wire logic [lbb_pkg::BandW-1:0]      border_i,
  input  wire logic [lbb_pkg::BandW-1:0]      ramp_i,
  output lbb_pkg::tag_t                       tag_o,
  output logic [lbb_pkg::D2W-1:0]             d2_o,
  output logic [lbb_pkg::T2W-1:0]             t2_o,
  output logic signed [lbb_pkg::ValW-1:0]     inner_o,
  output logic signed [lbb_pkg::DiffW-1:0]    diff_o
);

  localparam int unsigned BW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;

  logic [COORD_BITS-1:0] w_c, h_c;
  logic signed [BW-1:0] x, y, w, h, b, t, hi1, xhi2, xlo2, yhi2, ylo2, dxs, dys;
  logic is_outer, is_inner;

  // stage a
  lbb_pkg::tag_t a_tag_q, a_tag_d;
  logic [lbb_pkg::DistW-1:0] a_dx_q, a_dy_q, a_t_q;
  logic signed [lbb_pkg::ValW-1:0]  a_inner_q;
  logic signed [lbb_pkg::DiffW-1:0] a_diff_q;

  // stage b
  lbb_pkg::tag_t b_tag_q;
  logic [lbb_pkg::D2W-1:0] b_d2_q;
  logic [lbb_pkg::T2W-1:0] b_t2_q;
  logic signed [lbb_pkg::ValW-1:0]  b_inner_q;
  logic signed [lbb_pkg::DiffW-1:0] b_diff_q;

  logic [2*lbb_pkg::DistW-1:0] sq_x, sq_y, sq_t;

  always_comb begin
    w_c  = COORD_BITS'(grid_w_i);
    h_c  = COORD_BITS'(grid_h_i);
    x    = $signed(BW'(col_i));
    y    = $signed(BW'(row_i));
    w    = $signed(BW'(w_c));
    h    = $signed(BW'(h_c));
    b    = $signed(BW'(border_i));
    t    = $signed(BW'(ramp_i));
    hi1  = b + t;
    xhi2 = w - b;
    xlo2 = xhi2 - t;
    yhi2 = h - b;
    ylo2 = yhi2 - t;
    is_outer = (w_c == '0) || (h_c == '0) || (x < b) || (x >= xhi2) ||
               (y < b) || (y >= yhi2);
    is_inner = (x >= hi1) && (x < xlo2) && (y >= hi1) && (y < ylo2);
    if (x < hi1) begin
      dxs = hi1 - x;
    end else if (x >= xlo2) begin
      dxs = x - xlo2;
    end else begin
      dxs = '0;
    end
    if (y < hi1) begin
      dys = hi1 - y;
    end else if (y >= ylo2) begin
      dys = y - ylo2;
    end else begin
      dys = '0;
    end
    a_tag_d.vld  = take_i;
    a_tag_d.kind = is_outer ? lbb_pkg::KIND_OUTER :
                   is_inner ? lbb_pkg::KIND_INNER : lbb_pkg::KIND_RAMP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tag_q <= '0;
      b_tag_q <= '0;
    end else begin
      a_tag_q <= a_tag_d;
      b_tag_q <= a_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_dx_q    <= dxs[lbb_pkg::DistW-1:0];
    a_dy_q    <= dys[lbb_pkg::DistW-1:0];
    a_t_q     <= ramp_i;
    a_inner_q <= inner_i;
    a_diff_q  <= lbb_pkg::DiffW'(outer_i) - lbb_pkg::DiffW'(inner_i);
  end

  always_comb begin
    sq_x = a_dx_q * a_dx_q;
    sq_y = a_dy_q * a_dy_q;
    sq_t = a_t_q * a_t_q;
  end

  always_ff @(posedge clk_i) begin
    b_d2_q    <= lbb_pkg::D2W'(sq_x) + lbb_pkg::D2W'(sq_y);
    b_t2_q    <= sq_t;
    b_inner_q <= a_inner_q;
    b_diff_q  <= a_diff_q;
  end

  assign tag_o   = b_tag_q;
  assign d2_o    = b_d2_q;
  assign t2_o    = b_t2_q;
  assign inner_o = b_inner_q;
  assign diff_o  = b_diff_q;

endmodule
`default_nettype wire

// ===== rtl/core/lbb_queue.sv =====
`default_nettype none
module lbb_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lbb_back.sv =====
`default_nettype none
module lbb_back #(
  parameter int unsigned WEIGHT_FRAC_BITS = lbb_pkg::WeightFracBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lbb_pkg::tag_t                   tag_i,
  input  wire logic [lbb_pkg::D2W-1:0]         d2_i,
  input  wire logic [lbb_pkg::T2W-1:0]         t2_i,
  input  wire logic signed [lbb_pkg::ValW-1:0]  inner_i,
  input  wire logic signed [lbb_pkg::DiffW-1:0] diff_i,
  output logic                                 valid_o,
  output logic signed [lbb_pkg::ValW-1:0]      value_o
);

  localparam int unsigned F    = WEIGHT_FRAC_BITS;
  localparam int unsigned NDIV = 2 * F;
  localparam int unsigned NSQ  = F;
  localparam int unsigned NP   = 1 + NDIV + NSQ;
  localparam int unsigned RW   = lbb_pkg::D2W + 1;
  localparam int unsigned SW   = F + 2;
  localparam int unsigned PW   = F + 2 + lbb_pkg::DiffW;

  // carried along every stage
  logic                              pv_q    [NP];
  lbb_pkg::kind_e                    pk_q    [NP];
  logic                              pone_q  [NP];
  logic signed [lbb_pkg::ValW-1:0]   pinner_q[NP];
  logic signed [lbb_pkg::DiffW-1:0]  pdiff_q [NP];

  // divider: index 0 is the entry stage
  logic [RW-1:0]          drem_q [NDIV+1];
  logic [NDIV-1:0]        dq_q   [NDIV+1];
  logic [lbb_pkg::T2W-1:0] dt2_q [NDIV+1];

  // square root: index j holds the state after root stage j
  logic [SW-1:0]   srem_q [NSQ];
  logic [F-1:0]    sroot_q[NSQ];
  logic [NDIV-1:0] sq_q   [NSQ];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q[0] <= 1'b0;
    end else begin
      pv_q[0] <= tag_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pk_q[0]     <= tag_i.kind;
    pone_q[0]   <= (lbb_pkg::D2W'(t2_i) <= d2_i);
    pinner_q[0] <= inner_i;
    pdiff_q[0]  <= diff_i;
    drem_q[0]   <= RW'(d2_i);
    dq_q[0]     <= '0;
    dt2_q[0]    <= t2_i;
  end

  for (genvar s = 1; s < NP; s++) begin : g_carry
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[s] <= 1'b0;
      end else begin
        pv_q[s] <= pv_q[s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      pk_q[s]     <= pk_q[s-1];
      pone_q[s]   <= pone_q[s-1];
      pinner_q[s] <= pinner_q[s-1];
      pdiff_q[s]  <= pdiff_q[s-1];
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= NDIV; k++) begin : g_div
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = {drem_q[k-1][RW-2:0], 1'b0};
    assign ge = (sh >= RW'(dt2_q[k-1]));
    always_ff @(posedge clk_i) begin
      drem_q[k] <= ge ? (sh - RW'(dt2_q[k-1])) : sh;
      dq_q[k]   <= {dq_q[k-1][NDIV-2:0], ge};
      dt2_q[k]  <= dt2_q[k-1];
    end
  end

  // one root bit per stage, the first stage starts from the quotient
  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    logic [SW-1:0]   rem_in;
    logic [F-1:0]    root_in;
    logic [NDIV-1:0] q_in;
    logic [SW:0]     r, trial;
    logic            ge;
    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign q_in    = dq_q[NDIV];
    end else begin : g_next
      assign rem_in  = srem_q[j-1];
      assign root_in = sroot_q[j-1];
      assign q_in    = sq_q[j-1];
    end
    assign r     = {rem_in[SW-2:0], q_in[NDIV-1 -: 2]};
    assign trial = (SW+1)'({root_in, 2'b01});
    assign ge    = (r >= trial);
    always_ff @(posedge clk_i) begin
      srem_q[j]  <= SW'(ge ? (r - trial) : r);
      sroot_q[j] <= {root_in[F-2:0], ge};
      sq_q[j]    <= {q_in[NDIV-3:0], 2'b00};
    end
  end

  logic [F:0]                     wt;
  logic                           m_v_q, o_v_q;
  lbb_pkg::kind_e                 m_k_q;
  logic signed [PW-1:0]           m_prod_q, rnd;
  logic signed [lbb_pkg::ValW-1:0] m_inner_q, m_outer_q, o_val_q, ramp_val;

  assign wt = pone_q[NP-1] ? (F+1)'(1) << F : {1'b0, sroot_q[NSQ-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      m_v_q <= pv_q[NP-1];
      o_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_k_q     <= pk_q[NP-1];
    m_prod_q  <= $signed({1'b0, wt}) * pdiff_q[NP-1];
    m_inner_q <= pinner_q[NP-1];
    m_outer_q <= lbb_pkg::ValW'(pinner_q[NP-1] + pdiff_q[NP-1]);
  end

  // round half up, then floor shift
  always_comb begin
    rnd      = (m_prod_q + (PW'(1) << (F - 1))) >>> F;
    ramp_val = m_inner_q + lbb_pkg::ValW'(rnd);
  end

  always_ff @(posedge clk_i) begin
    case (m_k_q)
      lbb_pkg::KIND_OUTER: o_val_q <= m_outer_q;
      lbb_pkg::KIND_INNER: o_val_q <= m_inner_q;
      default:             o_val_q <= ramp_val;
    endcase
  end

  assign valid_o = o_v_q;
  assign value_o = o_val_q;

endmodule
`default_nettype wire

// ===== rtl/core/linear_border_blend_unit.sv =====
// channel  | direction | handshake          | payload
// config   | in        | cfg_we_i           | cfg_idx_i, cfg_wdata_i
// point    | in        | start_i & !busy_o  | col_i, row_i, inner_value_i, outer_value_i
// result   | out       | valid_o, one cycle | blended_value_o
//
// one beat per cycle in while busy_o is low, one beat per cycle out
// from accept to the result beat a point passes the front end, the queue and the back end,
// with its bit-per-stage divider (2F stages) and root (F stages)
// busy_o stays low: the back end drains the queue every cycle
// async active-low reset clears config to defaults and all valid bits
`default_nettype none
module linear_border_blend_unit #(
  parameter int unsigned COORD_BITS       = lbb_pkg::CoordBitsDef,
  parameter int unsigned WEIGHT_FRAC_BITS = lbb_pkg::WeightFracBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lbb_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [lbb_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic [COORD_BITS-1:0]           col_i,
  input  wire logic [COORD_BITS-1:0]           row_i,
  input  wire logic signed [lbb_pkg::ValW-1:0]  inner_value_i,
  input  wire logic signed [lbb_pkg::ValW-1:0]  outer_value_i,
  output logic                                 valid_o,
  output logic signed [lbb_pkg::ValW-1:0]      blended_value_o
);

  localparam int unsigned QW = 2 + lbb_pkg::D2W + lbb_pkg::T2W + lbb_pkg::ValW +
                               lbb_pkg::DiffW;

  // config registers
  logic [lbb_pkg::GridW-1:0] grid_w_q, grid_h_q;
  logic [lbb_pkg::BandW-1:0] border_q, ramp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= '0;
      grid_h_q <= '0;
      border_q <= '0;
      ramp_q   <= lbb_pkg::BandW'(1);
    end else if (cfg_we_i) begin
      unique case (lbb_pkg::cfg_reg_e'(cfg_idx_i))
        lbb_pkg::REG_GRID_WIDTH:  grid_w_q <= cfg_wdata_i;
        lbb_pkg::REG_GRID_HEIGHT: grid_h_q <= cfg_wdata_i;
        lbb_pkg::REG_BORDER:      border_q <= cfg_wdata_i[lbb_pkg::BandW-1:0];
        lbb_pkg::REG_RAMP:        ramp_q   <= cfg_wdata_i[lbb_pkg::BandW-1:0];
        default: ;
      endcase
    end
  end

  logic take;
  logic q_full, q_empty;
  assign take   = start_i && !busy_o;
  assign busy_o = q_full;

  // front end: classify the point, distances and squares
  lbb_pkg::tag_t                    f_tag;
  logic [lbb_pkg::D2W-1:0]          f_d2;
  logic [lbb_pkg::T2W-1:0]          f_t2;
  logic signed [lbb_pkg::ValW-1:0]  f_inner;
  logic signed [lbb_pkg::DiffW-1:0] f_diff;

  lbb_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .col_i    (col_i),
    .row_i    (row_i),
    .inner_i  (inner_value_i),
    .outer_i  (outer_value_i),
    .grid_w_i (grid_w_q),
    .grid_h_i (grid_h_q),
    .border_i (border_q),
    .ramp_i   (ramp_q),
    .tag_o    (f_tag),
    .d2_o     (f_d2),
    .t2_o     (f_t2),
    .inner_o  (f_inner),
    .diff_o   (f_diff)
  );

  // queue between front and back
  logic [QW-1:0] q_wdata, q_rdata;
  assign q_wdata = {f_tag.kind, f_d2, f_t2, f_inner, f_diff};

  lbb_queue #(.Width(QW), .Depth(4)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_tag.vld),
    .data_i  (q_wdata),
    .pop_i   (!q_empty),
    .data_o  (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  lbb_pkg::tag_t                    b_tag;
  logic [lbb_pkg::D2W-1:0]          b_d2;
  logic [lbb_pkg::T2W-1:0]          b_t2;
  logic signed [lbb_pkg::ValW-1:0]  b_inner;
  logic signed [lbb_pkg::DiffW-1:0] b_diff;

  always_comb begin
    b_tag.vld = !q_empty;
    {b_tag.kind, b_d2, b_t2, b_inner, b_diff} = q_rdata;
  end

  // back end: divide, root, scale and round, then pick the outer, inner or ramp value
  lbb_back #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (b_tag),
    .d2_i    (b_d2),
    .t2_i    (b_t2),
    .inner_i (b_inner),
    .diff_i  (b_diff),
    .valid_o (valid_o),
    .value_o (blended_value_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/lbb_checker.sv =====
`default_nettype none
module lbb_checker #(
  parameter int unsigned COORD_BITS       = lbb_pkg::CoordBitsDef,
  parameter int unsigned WEIGHT_FRAC_BITS = lbb_pkg::WeightFracBitsDef
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            cfg_we_i,
  input wire logic [lbb_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input wire logic [lbb_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input wire logic                            start_i,
  input wire logic                            busy_o,
  input wire logic [COORD_BITS-1:0]           col_i,
  input wire logic [COORD_BITS-1:0]           row_i,
  input wire logic signed [lbb_pkg::ValW-1:0]  inner_value_i,
  input wire logic signed [lbb_pkg::ValW-1:0]  outer_value_i,
  input wire logic                            valid_o,
  input wire logic signed [lbb_pkg::ValW-1:0]  blended_value_o
);

  localparam int unsigned Lat = 6 + 3 * WEIGHT_FRAC_BITS;

  logic acc;
  assign acc = start_i && !busy_o && rst_ni;

  // the queue never fills, so points are always taken
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  // every accepted point yields exactly one beat, a fixed time later
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == $past(acc, Lat))
    else $error("result beat out of step with accepted points");

  // the blend lies between the inner and outer value
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |->
      ((blended_value_o >= $past(inner_value_i, Lat)) &&
       (blended_value_o <= $past(outer_value_i, Lat))) ||
      ((blended_value_o <= $past(inner_value_i, Lat)) &&
       (blended_value_o >= $past(outer_value_i, Lat))))
    else $error("blend outside inner/outer range");

endmodule

bind linear_border_blend_unit lbb_checker #(
  .COORD_BITS       (COORD_BITS),
  .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
) u_lbb_checker (.*);
`default_nettype wire

// ===== verif/linear_border_blend_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module linear_border_blend_unit_tb;

  // pipeline depth of the block, from accept to result beat
  localparam int unsigned PipeLat   = 6 + 3 * lbb_pkg::WeightFracBitsDef;
  localparam longint unsigned CycleLimit = 400000;

  // one point beat
  typedef struct packed {
    logic [15:0]        col;
    logic [15:0]        row;
    logic signed [31:0] inner;
    logic signed [31:0] outer;
  } point_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [lbb_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [lbb_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [15:0]        col_i = '0;
  logic [15:0]        row_i = '0;
  logic signed [31:0] inner_value_i = '0;
  logic signed [31:0] outer_value_i = '0;
  logic               valid_o;
  logic signed [31:0] blended_value_o;

  linear_border_blend_unit DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .start_i, .busy_o, .col_i, .row_i, .inner_value_i, .outer_value_i,
    .valid_o, .blended_value_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow copy of the config registers
  longint grid_w, grid_h, band_w, ramp_w;

  point_t             point_q[$];   // points waiting for the driver
  logic signed [31:0] blend_q[$];   // blends expected on the result port
  int                 gap_left;
  int                 mismatches;
  longint unsigned    cycles;

  function automatic longint ramp_dist(longint p, longint hi1, longint lo2);
    if (p < hi1) return hi1 - p;
    if (p >= lo2) return p - lo2;
    return 0;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // expected blend for one point under the shadow config
  function automatic logic signed [31:0] blend_of(point_t p);
    longint x, y, inn, outv, lo1, hi1, xhi2, xlo2, yhi2, ylo2, res, diff, prod;
    longint unsigned dx, dy, d2, t2, wgt, rem, quo, one;
    x = p.col;
    y = p.row;
    inn = p.inner;
    outv = p.outer;
    lo1 = band_w;
    hi1 = band_w + ramp_w;
    xhi2 = grid_w - band_w;
    xlo2 = xhi2 - ramp_w;
    yhi2 = grid_h - band_w;
    ylo2 = yhi2 - ramp_w;
    one = 64'd1 << lbb_pkg::WeightFracBitsDef;
    if (grid_w == 0 || grid_h == 0 || x < lo1 || x >= xhi2 || y < lo1 || y >= yhi2) begin
      res = outv;
    end else if (x >= hi1 && x < xlo2 && y >= hi1 && y < ylo2) begin
      res = inn;
    end else begin
      dx = ramp_dist(x, hi1, xlo2);
      dy = ramp_dist(y, hi1, ylo2);
      d2 = dx * dx + dy * dy;
      t2 = ramp_w * ramp_w;
      if (d2 >= t2) begin
        wgt = one;
      end else begin
        // bit-serial fraction d2 / t2 with 2F fraction bits
        rem = d2;
        quo = 0;
        for (int i = 0; i < 2 * lbb_pkg::WeightFracBitsDef; i++) begin
          rem <<= 1;
          quo <<= 1;
          if (rem >= t2) begin
            rem -= t2;
            quo |= 1;
          end
        end
        wgt = int_sqrt(quo);
        if (wgt > one) wgt = one;
      end
      diff = outv - inn;
      prod = longint'(wgt) * diff + (longint'(1) << (lbb_pkg::WeightFracBitsDef - 1));
      res = inn + (prod >>> lbb_pkg::WeightFracBitsDef);   // arithmetic shift floors
    end
    return res[31:0];
  endfunction

  task automatic set_reg(lbb_pkg::cfg_reg_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[15:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lbb_pkg::REG_GRID_WIDTH:  grid_w = val & 16'hFFFF;
      lbb_pkg::REG_GRID_HEIGHT: grid_h = val & 16'hFFFF;
      lbb_pkg::REG_BORDER:      band_w = val & 15'h7FFF;
      default:                  ramp_w = val & 15'h7FFF;
    endcase
  endtask

  task automatic load_geometry(int unsigned gw, int unsigned gh, int unsigned bw,
                               int unsigned rw);
    set_reg(lbb_pkg::REG_GRID_WIDTH, gw);
    set_reg(lbb_pkg::REG_GRID_HEIGHT, gh);
    set_reg(lbb_pkg::REG_BORDER, bw);
    set_reg(lbb_pkg::REG_RAMP, rw);
  endtask

  // wait for the pipeline to drain before touching config
  task automatic drain;
    wait (point_q.size() == 0 && !start_i);
    wait (blend_q.size() == 0);
    repeat (PipeLat + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  // coordinates biased toward the bands of the current geometry
  function automatic logic [15:0] rand_coord(longint size);
    longint edge_pos;
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1, 2, 3: begin
        edge_pos = band_w + ramp_w + 3;
        return 16'($urandom_range(0, 32'(edge_pos)));
      end
      4, 5, 6: begin
        edge_pos = size - band_w - ramp_w - 3;
        if (edge_pos < 0) edge_pos = 0;
        return 16'($urandom_range(32'(edge_pos), 32'(size + 2)));
      end
      default: return 16'($urandom_range(0, size > 0 ? 32'(size - 1) : 0));
    endcase
  endfunction

  task automatic push_point(logic [15:0] c, logic [15:0] r, logic [31:0] iv,
                            logic [31:0] ov);
    point_t p;
    p.col = c;
    p.row = r;
    p.inner = iv;
    p.outer = ov;
    point_q.push_back(p);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      push_point(rand_coord(grid_w), rand_coord(grid_h), rand_val(), rand_val());
      if ($urandom_range(0, 31) == 0) wait (point_q.size() < 4);
    end
  endtask

  // driver: pops the point queue, random gaps between beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // the accepted beat leaves the queue, the head is then the next one
      if (start_i && !busy_o) begin
        blend_q.push_back(blend_of(point_q[0]));
        void'(point_q.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (point_q.size() > 0) begin
        point_t nxt;
        nxt = point_q[0];
        start_i <= 1'b1;
        col_i <= nxt.col;
        row_i <= nxt.row;
        inner_value_i <= nxt.inner;
        outer_value_i <= nxt.outer;
        // mostly back to back, sometimes a short or long pause
        case ($urandom_range(0, 15))
          0, 1: gap_left <= $urandom_range(1, 3);
          2:    gap_left <= $urandom_range(10, 40);
          default: gap_left <= 0;
        endcase
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: every valid beat checks against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (valid_o) begin
        if (blend_q.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected result beat %h", blended_value_o);
        end else begin
          if (blended_value_o !== blend_q[0]) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("blend mismatch: expected %h got %h",
                       blend_q[0], blended_value_o);
          end
          void'(blend_q.pop_front());
        end
      end
      if (cycles > CycleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    gap_left = 0;
    mismatches = 0;
    cycles = 0;
    grid_w = 0;
    grid_h = 0;
    band_w = 0;
    ramp_w = 1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: zero grid, every point gives the outer value
    push_point(16'd0, 16'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    push_point(16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();

    // regular geometry: outer band, ramps, corners, interior
    load_geometry(100, 80, 5, 10);
    push_point(16'd0, 16'd40, 32'h0001_0000, 32'h0005_0000);      // outer band
    push_point(16'd50, 16'd40, 32'h0001_0000, 32'h0005_0000);     // interior
    push_point(16'd5, 16'd40, 32'h0001_0000, 32'h0005_0000);      // ramp start
    push_point(16'd10, 16'd40, 32'h7FFF_FFFF, 32'h8000_0000);     // mid ramp, extremes
    push_point(16'd94, 16'd40, 32'h8000_0000, 32'h7FFF_FFFF);     // right ramp
    push_point(16'd50, 16'd74, 32'h0000_0001, 32'hFFFF_FFFF);     // bottom ramp
    push_point(16'd7, 16'd7, 32'h0010_0000, 32'hFFF0_0000);       // corner square
    push_point(16'd92, 16'd72, 32'h1234_5678, 32'h8765_4321);     // far corner
    push_point(16'd14, 16'd14, 32'h0000_0000, 32'h0000_0003);     // corner ramp, small difference
    push_point(16'hFFFF, 16'd40, 32'h0, 32'h1);
    drain();

    // zero ramp width, undersized grid
    load_geometry(12, 9, 3, 0);
    push_point(16'd3, 16'd3, 32'h1, 32'h2);
    push_point(16'd6, 16'd4, 32'h1, 32'h2);
    drain();
    load_geometry(10, 20, 2, 7);   // bands overlap across the width
    push_point(16'd4, 16'd10, 32'h0100_0000, 32'hFF00_0000);
    push_point(16'd6, 16'd3, 32'h0100_0000, 32'hFF00_0000);
    drain();
    // one zero size only
    load_geometry(100, 0, 0, 1);
    push_point(16'd50, 16'd50, 32'h5, 32'h9);
    drain();

    // random phases over several geometries, extremes included
    load_geometry(200, 150, 4, 20);
    random_phase(350);
    drain();   // sender waits for every result
    load_geometry(65535, 65535, 32767, 32767);
    random_phase(150);
    drain();
    load_geometry(64, 64, 0, 1);
    random_phase(250);
    drain();
    load_geometry(30, 500, 3, 12);
    random_phase(250);
    drain();
    load_geometry(65535, 1000, 100, 32767);
    random_phase(150);
    drain();
    load_geometry($urandom_range(1, 4000), $urandom_range(1, 4000),
                  $urandom_range(0, 300), $urandom_range(0, 600));
    random_phase(250);
    drain();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/lbb_pkg.sv
rtl/core/lbb_front.sv
rtl/core/lbb_queue.sv
rtl/core/lbb_back.sv
rtl/core/linear_border_blend_unit.sv
rtl/core/lbb_checker.sv
verif/linear_border_blend_unit_tb.sv
